FILE: hw/rtl/fpa_pkg.sv
// shared types and constants of the fixed-point alu
package fpa_pkg;

  localparam int unsigned DataW           = 32;
  localparam int unsigned FracBitsDefault = 8;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MAX      = 4'd10,
    OP_MIN      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_e;

  // per-item control carried alongside the divider datapath
  typedef struct packed {
    logic             is_div;
    logic             neg;
    logic             zero;
    logic             flag;
    logic [DataW-1:0] res;
  } ctl_t;

endpackage

FILE: hw/rtl/fpa_prep.sv
// first stage: decode, multiply, simple ops and divider operand set-up
module fpa_prep #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault,
  parameter int unsigned QW        = fpa_pkg::DataW + FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [3:0]                    req_type_i,
  input  logic signed [fpa_pkg::DataW-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DataW-1:0] operand_b_i,
  output logic                          valid_o,
  output fpa_pkg::ctl_t                 ctl_o,
  output logic [QW-1:0]                 dvd_o,
  output logic [fpa_pkg::DataW-1:0]     dsr_o
);
  import fpa_pkg::*;

  logic                    valid_q;
  ctl_t                    ctl_d, ctl_q;
  logic [QW-1:0]           dvd_q;
  logic [DataW-1:0]        dsr_q;
  logic [DataW-1:0]        abs_a, abs_b;
  logic signed [2*DataW-1:0] prod;
  logic signed [DataW-1:0] bias, biased;
  logic                    gt, lt;
  op_e                     op;

  assign op     = op_e'(req_type_i);
  assign abs_a  = operand_a_i[DataW-1] ? (~operand_a_i + 1'b1) : operand_a_i;
  assign abs_b  = operand_b_i[DataW-1] ? (~operand_b_i + 1'b1) : operand_b_i;
  assign prod   = operand_a_i * operand_b_i;
  assign bias   = operand_a_i[DataW-1] ? DataW'((64'd1 << FRAC_BITS) - 64'd1) : '0;
  assign biased = operand_a_i + bias;
  assign gt     = operand_a_i > operand_b_i;
  assign lt     = operand_a_i < operand_b_i;

  // result of every operation but divide
  always_comb begin
    ctl_d        = '0;
    ctl_d.is_div = (op == OP_DIV);
    ctl_d.neg    = operand_a_i[DataW-1] ^ operand_b_i[DataW-1];
    ctl_d.zero   = (operand_b_i == '0);
    case (op)
      OP_ADD:      ctl_d.res = operand_a_i + operand_b_i;
      OP_SUB:      ctl_d.res = operand_a_i - operand_b_i;
      OP_MUL:      ctl_d.res = prod[FRAC_BITS +: DataW];
      OP_DIV:      ctl_d.res = '0;
      OP_GT:       ctl_d.flag = gt;
      OP_LT:       ctl_d.flag = lt;
      OP_GE:       ctl_d.flag = !lt;
      OP_LE:       ctl_d.flag = !gt;
      OP_EQ:       ctl_d.flag = (operand_a_i == operand_b_i);
      OP_NE:       ctl_d.flag = (operand_a_i != operand_b_i);
      OP_MAX:      ctl_d.res = gt ? operand_a_i : operand_b_i;
      OP_MIN:      ctl_d.res = lt ? operand_a_i : operand_b_i;
      OP_INC:      ctl_d.res = operand_a_i + 1'b1;
      OP_DEC:      ctl_d.res = operand_a_i - 1'b1;
      OP_FROM_INT: ctl_d.res = operand_a_i <<< FRAC_BITS;
      OP_TO_INT:   ctl_d.res = biased >>> FRAC_BITS;
      default:     ctl_d.res = '0;
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_d;
      dvd_q <= {abs_a, {FRAC_BITS{1'b0}}};
      dsr_q <= abs_b;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign dvd_o   = dvd_q;
  assign dsr_o   = dsr_q;

endmodule

FILE: hw/rtl/fpa_div_stage.sv
// one restoring-division step: one quotient bit per stage
module fpa_div_stage #(
  parameter int unsigned QW = fpa_pkg::DataW + fpa_pkg::FracBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  fpa_pkg::ctl_t             ctl_i,
  input  logic [fpa_pkg::DataW-1:0] rem_i,
  input  logic [QW-1:0]             dvd_i,
  input  logic [fpa_pkg::DataW-1:0] dsr_i,
  output logic                      valid_o,
  output fpa_pkg::ctl_t             ctl_o,
  output logic [fpa_pkg::DataW-1:0] rem_o,
  output logic [QW-1:0]             dvd_o,
  output logic [fpa_pkg::DataW-1:0] dsr_o
);
  import fpa_pkg::*;

  logic             valid_q;
  ctl_t             ctl_q;
  logic [DataW-1:0] rem_d, rem_q;
  logic [QW-1:0]    dvd_q;
  logic [DataW-1:0] dsr_q;
  logic [DataW:0]   trial, diff;
  logic             ge;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem_i, dvd_i[QW-1]};
  assign diff  = trial - {1'b0, dsr_i};
  assign ge    = trial >= {1'b0, dsr_i};
  assign rem_d = ge ? diff[DataW-1:0] : trial[DataW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // quotient bits enter at the bottom as the dividend leaves at the top
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_i;
      rem_q <= rem_d;
      dvd_q <= {dvd_i[QW-2:0], ge};
      dsr_q <= dsr_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign rem_o   = rem_q;
  assign dvd_o   = dvd_q;
  assign dsr_o   = dsr_q;

endmodule

FILE: hw/rtl/fixed_point_alu.sv
// top level of the pipelined fixed-point alu
//
//  channel | direction | handshake               | fields
//  request | in        | in_valid_i / in_stall_o   | req_type_i operand_a_i operand_b_i
//  result  | out       | out_valid_o / out_stall_i | result_value_o compare_true_o
//
// the pipeline holds one set-up stage, 32 + FRAC_BITS divider steps
// (one quotient bit each) and the output register; one item enters every cycle unless a held result is stalled.
// reset clears the valid bits only.
// a stalled result freezes the whole pipeline, so the request side stalls the same cycle.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [3:0]                       req_type_i,
  input  logic signed [fpa_pkg::DataW-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DataW-1:0] operand_b_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [fpa_pkg::DataW-1:0] result_value_o,
  output logic                             compare_true_o
);
  import fpa_pkg::*;

  localparam int unsigned QW = DataW + FRAC_BITS;

  logic             en;
  logic             vld   [QW+1];
  ctl_t             ctl   [QW+1];
  logic [DataW-1:0] rem   [QW+1];
  logic [QW-1:0]    dvd   [QW+1];
  logic [DataW-1:0] dsr   [QW+1];
  logic             out_valid_q;
  logic [DataW-1:0] res_d, res_q;
  logic             flag_q;
  logic [DataW-1:0] quo;

  // global advance unless the held result is stalled
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  fpa_prep #(
    .FRAC_BITS(FRAC_BITS),
    .QW       (QW)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .req_type_i (req_type_i),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .valid_o    (vld[0]),
    .ctl_o      (ctl[0]),
    .dvd_o      (dvd[0]),
    .dsr_o      (dsr[0])
  );
  assign rem[0] = '0;

  // divider chain
  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_stage #(
      .QW(QW)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(vld[i]),
      .ctl_i  (ctl[i]),
      .rem_i  (rem[i]),
      .dvd_i  (dvd[i]),
      .dsr_i  (dsr[i]),
      .valid_o(vld[i+1]),
      .ctl_o  (ctl[i+1]),
      .rem_o  (rem[i+1]),
      .dvd_o  (dvd[i+1]),
      .dsr_o  (dsr[i+1])
    );
  end

  // sign fix-up of the quotient and final select
  assign quo = dvd[QW][DataW-1:0];
  always_comb begin
    if (!ctl[QW].is_div) begin
      res_d = ctl[QW].res;
    end else if (ctl[QW].zero) begin
      res_d = '0;
    end else begin
      res_d = ctl[QW].neg ? (~quo + 1'b1) : quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      flag_q <= ctl[QW].flag;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign compare_true_o = flag_q;

`ifndef SYNTHESIS
  // a comparison never carries a value
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compare_true_o |-> result_value_o == '0)
    else $error("comparison item with non-zero value");

  // a frozen pipeline keeps its first stage
  a_hold_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld[0]) && $stable(dvd[0]))
    else $error("first stage moved during stall");

  // the request side stalls only when a valid result is held by a stall
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("request stalled without a held result");
`endif

endmodule

FILE: tb/testbench.sv
// self-checking testbench of the pipelined fixed-point alu
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int unsigned Frac      = FracBitsDefault;
  localparam int unsigned Latency   = Frac + 34;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    op_e               op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } request_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               flag;
  } answer_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [3:0] req_type_i;
  logic signed [31:0] operand_a_i, operand_b_i, result_value_o;
  logic compare_true_o;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit stim_done = 0;
  bit in_taken = 0;
  int in_gap = 0, out_gap = 0;

  fixed_point_alu #(.FRAC_BITS(Frac)) dut (.*);

  // clock
  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // fixed-point alu prediction
  function automatic answer_t alu_answer(request_t r);
    answer_t ans;
    logic signed [63:0] a, b, p, q;
    a = r.a;
    b = r.b;
    ans = '0;
    case (r.op)
      OP_ADD: ans.value = a + b;
      OP_SUB: ans.value = a - b;
      OP_MUL: begin
        p = a * b;
        ans.value = p >>> Frac;
      end
      OP_DIV: begin
        if (b == 0) ans.value = 0;
        else begin
          q = (a <<< Frac) / b;
          ans.value = q;
        end
      end
      OP_GT: ans.flag = a > b;
      OP_LT: ans.flag = a < b;
      OP_GE: ans.flag = a >= b;
      OP_LE: ans.flag = a <= b;
      OP_EQ: ans.flag = a == b;
      OP_NE: ans.flag = a != b;
      OP_MAX: ans.value = (a > b) ? a : b;
      OP_MIN: ans.value = (a < b) ? a : b;
      OP_INC: ans.value = a + 1;
      OP_DEC: ans.value = a - 1;
      OP_FROM_INT: ans.value = a <<< Frac;
      default: ans.value = a / (64'sd1 <<< Frac);
    endcase
    return ans;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 4)) - 2;
      3: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
      4: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
      default: return $urandom;
    endcase
  endfunction

  // request driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
    end else if (!in_valid_i || in_taken) begin
      if (in_taken) expected_answers.push_back(alu_answer({op_e'(req_type_i),
          operand_a_i, operand_b_i}));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 0;
      end else if (pending_reqs.size() > 0) begin
        request_t r;
        r = pending_reqs.pop_front();
        in_valid_i <= 1;
        req_type_i <= r.op;
        operand_a_i <= r.a;
        operand_b_i <= r.b;
        in_gap <= (cycles % 2000 < 300) ? 0 : gap_len();
      end else begin
        in_valid_i <= 0;
        stim_done <= 1;
      end
    end
  end

  // result stall generator
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= 0;
      out_gap <= (cycles % 2000 < 300) ? 0 : gap_len();
    end
  end

  // result monitor and request acceptance
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_answers.size() == 0) begin
        $error("result item with no expectation: value %0d", result_value_o);
        errors++;
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (result_value_o !== e.value) begin
          $error("result_value expected %0d actual %0d", e.value, result_value_o);
          errors++;
        end
        if (compare_true_o !== e.flag) begin
          $error("compare_true expected %0d actual %0d", e.flag, compare_true_o);
          errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    request_t r;
    in_valid_i = 0; out_stall_i = 0;
    req_type_i = OP_ADD; operand_a_i = 0; operand_b_i = 0;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    // directed: every operation on the extremes and special cases
    for (int k = 0; k < 16; k++) begin
      r.op = op_e'(k);
      r.a = 32'sh80000000;
      r.b = (k == OP_DIV) ? 32'sd0 : 32'sh7fffffff;
      pending_reqs.push_back(r);
    end
    pending_reqs.push_back('{OP_DIV, 32'sh80000000, 32'sd1});
    pending_reqs.push_back('{OP_MAX, 32'sd5, 32'sd5});
    pending_reqs.push_back('{OP_MIN, -32'sd5, -32'sd5});
    pending_reqs.push_back('{OP_EQ, 32'sd7, 32'sd7});
    pending_reqs.push_back('{OP_MUL, -32'sd1, 32'sd1});
    pending_reqs.push_back('{OP_TO_INT, -32'sd1, 32'sd0});
    pending_reqs.push_back('{OP_INC, 32'sh7fffffff, 32'sh7fffffff});
    pending_reqs.push_back('{OP_DIV, -32'sd300, 32'sd7});
    // random items
    repeat (1800) begin
      r.op = op_e'($urandom_range(0, 15));
      r.a = pick_operand();
      r.b = ($urandom_range(0, 9) == 0) ? pick_operand() - pick_operand() + r.a
                                        : pick_operand();
      if ($urandom_range(0, 15) == 0) r.b = r.a;
      pending_reqs.push_back(r);
    end
    wait (stim_done && expected_answers.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // timeout
  initial begin
    wait (cycles >= CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
